// ===== hw/rtl/cle_pkg.sv =====
// Shared types, codes and byte tests for the console line editor.
// No dependencies; used by cle_classify and console_line_editor_top.
package cle_pkg;

    // Default line store depth.
    localparam int LINE_LENGTH_DEF = 40;

    // Echo action codes.
    localparam logic [2:0] ACT_ECHO    = 3'd0;
    localparam logic [2:0] ACT_ERASE   = 3'd1;
    localparam logic [2:0] ACT_BELL    = 3'd2;
    localparam logic [2:0] ACT_NEWLINE = 3'd3;
    localparam logic [2:0] ACT_END     = 3'd4;

    // Control bytes.
    localparam logic [7:0] BYTE_EOT    = 8'd4;
    localparam logic [7:0] BYTE_BS     = 8'd8;
    localparam logic [7:0] BYTE_DEL    = 8'd127;
    localparam logic [7:0] BYTE_KILL   = 8'd21;
    localparam logic [7:0] BYTE_WERASE = 8'd23;

    // Whitespace range and printable range.
    localparam logic [7:0] BYTE_TAB    = 8'd9;
    localparam logic [7:0] BYTE_CR     = 8'd13;
    localparam logic [7:0] BYTE_SPACE  = 8'd32;
    localparam logic [7:0] BYTE_TILDE  = 8'd126;

    typedef struct packed {
        logic is_eot;
        logic is_erase;
        logic is_kill;
        logic is_werase;
        logic is_storable;
    } t_byte_class;

    function automatic logic f_is_blank(input logic [7:0] b);
        return (b == BYTE_SPACE) || ((b >= BYTE_TAB) && (b <= BYTE_CR));
    endfunction

    function automatic logic f_is_storable(input logic [7:0] b);
        return ((b >= BYTE_SPACE) && (b <= BYTE_TILDE)) || ((b >= BYTE_TAB) && (b <= BYTE_CR));
    endfunction

endpackage

// ===== hw/rtl/cle_classify.sv =====
// Sorts a received byte into the editing classes of the line editor.
// Depends on cle_pkg.
module cle_classify (
    input  logic [7:0]               i_byte,
    output cle_pkg::t_byte_class     o_class
);

    always_comb begin
        o_class             = '0;
        o_class.is_storable = cle_pkg::f_is_storable(i_byte);
        unique case (i_byte) inside
            cle_pkg::BYTE_EOT:                    o_class.is_eot    = 1'b1;
            cle_pkg::BYTE_BS, cle_pkg::BYTE_DEL:  o_class.is_erase  = 1'b1;
            cle_pkg::BYTE_KILL:                   o_class.is_kill   = 1'b1;
            cle_pkg::BYTE_WERASE:                 o_class.is_werase = 1'b1;
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/console_line_editor_top.sv =====
// Console line editor: line store, cursor and echo action sequencer.
// Depends on cle_pkg and cle_classify.
//
//  channel   dir  tdata fields (low bit up)              tuser  tlast
//  s (byte)  in   in_byte [7:0]                           -      -
//  m (echo)  out  action [2:0], out_char [10:3], pad 0    -      last
//
//  Steps: a byte is taken in S_IDLE and decided in S_DECIDE, which sends
//  any echo word. Storing into a full line sends the newline word from
//  S_DECIDE, then the echo word from S_ECHO. Line kill and word erase go
//  from S_DECIDE to S_RUN, which sends one erase word per erased character;
//  the line store is read ahead, at the two entries just below the cursor,
//  so each erase step needs no wait.
//  Reset clears the cursor, the session-end flag and the sequencer; the line
//  store is not cleared (only entries below the cursor are ever used).
//  Stalls: the echo word sits in an output register; while it is not taken
//  the sequencer holds its step, so the input stalls once a taken byte needs
//  a word; kill or word erase on an empty line and dropped bytes need none.
module console_line_editor_top #(
    parameter int LINE_LENGTH = cle_pkg::LINE_LENGTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // received byte: [7:0] in_byte
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    // echo word: [2:0] action, [10:3] out_char, [15:11] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,
    output logic        m_axis_tlast
);

    // Cursor runs 0..LINE_LENGTH; store index runs 0..LINE_LENGTH-1.
    localparam int CW = $clog2(LINE_LENGTH + 1);
    localparam int IW = $clog2(LINE_LENGTH);
    localparam logic [CW-1:0] LINE_LEN_C = CW'(LINE_LENGTH);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_DECIDE = 4'b0010,
        S_ECHO   = 4'b0100,
        S_RUN    = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_cursor, n_cursor;
    logic r_finished, n_finished;
    logic r_run_word, n_run_word;       // run is a word erase, else a line kill
    logic r_blank_phase, n_blank_phase; // word erase still eating trailing blanks
    logic [7:0] r_byte;

    // Line store with two registered read ports.
    logic [7:0] r_line_store [LINE_LENGTH];
    logic [7:0] r_rd1;      // entry at cursor - 1
    logic [7:0] r_rd2;      // entry at cursor - 2
    logic [IW-1:0] rd_addr1, rd_addr2, wr_addr;
    logic wr_en;

    // Output register.
    logic r_out_valid;
    logic [2:0] r_out_action;
    logic [7:0] r_out_char;
    logic r_out_last;

    logic out_free;
    logic emit, em_last;
    logic [2:0] em_action;
    logic [7:0] em_char;

    cle_pkg::t_byte_class cls;

    cle_classify u_classify (
        .i_byte  (r_byte),
        .o_class (cls)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign out_free      = !r_out_valid || m_axis_tready;

    always_comb begin
        n_state       = r_state;
        n_cursor      = r_cursor;
        n_finished    = r_finished;
        n_run_word    = r_run_word;
        n_blank_phase = r_blank_phase;
        emit          = 1'b0;
        em_action     = cle_pkg::ACT_BELL;
        em_char       = 8'd0;
        em_last       = 1'b1;
        wr_en         = 1'b0;
        wr_addr       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_finished) begin
                    // drop every byte after session end
                    n_state = S_IDLE;
                end else if (cls.is_eot && (r_cursor == '0)) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        em_action  = cle_pkg::ACT_END;
                        n_finished = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else if (cls.is_erase) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        n_state = S_IDLE;
                        if (r_cursor != '0) begin
                            em_action = cle_pkg::ACT_ERASE;
                            n_cursor  = r_cursor - CW'(1);
                        end
                    end
                end else if (cls.is_kill || cls.is_werase) begin
                    // empty line: nothing to erase, no word
                    if (r_cursor == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_run_word    = cls.is_werase;
                        n_blank_phase = 1'b1;
                        n_state       = S_RUN;
                    end
                end else if (!cls.is_storable) begin
                    if (out_free) begin
                        emit    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (r_cursor >= LINE_LEN_C) begin
                    // full line: wrap first, store in the next step
                    if (out_free) begin
                        emit      = 1'b1;
                        em_action = cle_pkg::ACT_NEWLINE;
                        em_last   = 1'b0;
                        n_cursor  = '0;
                        n_state   = S_ECHO;
                    end
                end else if (out_free) begin
                    wr_en     = 1'b1;
                    wr_addr   = r_cursor[IW-1:0];
                    n_cursor  = r_cursor + CW'(1);
                    emit      = 1'b1;
                    em_action = cle_pkg::ACT_ECHO;
                    em_char   = r_byte;
                    n_state   = S_IDLE;
                end
            end
            S_ECHO: begin
                if (out_free) begin
                    wr_en     = 1'b1;
                    wr_addr   = '0;
                    n_cursor  = CW'(1);
                    emit      = 1'b1;
                    em_action = cle_pkg::ACT_ECHO;
                    em_char   = r_byte;
                    n_state   = S_IDLE;
                end
            end
            S_RUN: begin
                if (out_free) begin
                    emit      = 1'b1;
                    em_action = cle_pkg::ACT_ERASE;
                    n_cursor  = r_cursor - CW'(1);
                    if (!r_run_word) begin
                        em_last = (r_cursor == CW'(1));
                    end else if (r_blank_phase && cle_pkg::f_is_blank(r_rd1)) begin
                        em_last = (r_cursor == CW'(1));
                    end else begin
                        // inside the word: stop where the next char is blank
                        n_blank_phase = 1'b0;
                        em_last = (r_cursor == CW'(1)) || cle_pkg::f_is_blank(r_rd2);
                    end
                    if (em_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Read ahead at the next cursor, registered, so r_rd1/r_rd2 track r_cursor.
    always_comb begin
        rd_addr1 = (n_cursor != '0) ? IW'(n_cursor - CW'(1)) : '0;
        rd_addr2 = (n_cursor >= CW'(2)) ? IW'(n_cursor - CW'(2)) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_line_store[wr_addr] <= r_byte;
        // forward a same-cycle write to the read ports
        r_rd1 <= (wr_en && (wr_addr == rd_addr1)) ? r_byte : r_line_store[rd_addr1];
        r_rd2 <= (wr_en && (wr_addr == rd_addr2)) ? r_byte : r_line_store[rd_addr2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cursor      <= '0;
            r_finished    <= 1'b0;
            r_run_word    <= 1'b0;
            r_blank_phase <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cursor      <= n_cursor;
            r_finished    <= n_finished;
            r_run_word    <= n_run_word;
            r_blank_phase <= n_blank_phase;
            if (emit)               r_out_valid <= 1'b1;
            else if (m_axis_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) r_byte <= s_axis_tdata;
        if (emit) begin
            r_out_action <= em_action;
            r_out_char   <= em_char;
            r_out_last   <= em_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_char, r_out_action};
    assign m_axis_tlast  = r_out_last;

    // Cursor never runs past the line length.
    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= LINE_LEN_C)
        else $error("cursor beyond line length");

    // An erase run always has a character left to erase.
    a_run_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_cursor != '0))
        else $error("erase run on empty line");

    // After session end and a drained output, no further echo words.
    a_silent_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_finished && !m_axis_tvalid) |=> !m_axis_tvalid)
        else $error("echo word after session end");

    // Store writes stay inside the line.
    a_write_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (CW'(wr_addr) < LINE_LEN_C))
        else $error("line store write out of range");

endmodule

// ===== bench/console_line_editor_top_tb.sv =====
// Self-checking bench for console_line_editor_top: drives keyboard bytes,
// predicts the echo words and checks every word the block sends out.
// Depends on cle_pkg and the console_line_editor_top RTL.
`timescale 1ns / 1ps

module console_line_editor_top_tb;

    localparam int LINE_LEN    = cle_pkg::LINE_LENGTH_DEF;
    localparam int RANDOM_KEYS = 220;
    localparam int CALM_KEYS   = 40;   // final random keys sent with no idling
    localparam int LONG_HOLD   = 80;   // receiver hold-off, in cycles

    // One predicted echo word.
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] ch;
        logic       last;
    } t_echo_word;

    // Line editor predictor plus the queue of echo words still owed by the block.
    class t_echo_scoreboard;
        logic [7:0]  line_buf [LINE_LEN];
        int unsigned col;
        bit          ended;
        t_echo_word  owed_q [$];
        int          errors;

        function new();
            col    = 0;
            ended  = 1'b0;
            errors = 0;
            foreach (line_buf[i]) line_buf[i] = 8'd0;
        endfunction

        function bit is_space_like(logic [7:0] b);
            return (b == cle_pkg::BYTE_SPACE) ||
                   ((b >= cle_pkg::BYTE_TAB) && (b <= cle_pkg::BYTE_CR));
        endfunction

        function void push(logic [2:0] act, logic [7:0] ch);
            t_echo_word w;
            w.action = act;
            w.ch     = ch;
            w.last   = 1'b0;
            owed_q.push_back(w);
        endfunction

        function void erase_char();
            col--;
            push(cle_pkg::ACT_ERASE, 8'd0);
        endfunction

        // Advance the line state by one accepted byte and queue its echo words.
        function void note_byte(logic [7:0] b);
            int first;
            if (ended) return;
            first = owed_q.size();
            if (col > LINE_LEN) col = LINE_LEN;

            if (b == cle_pkg::BYTE_EOT && col == 0) begin
                ended = 1'b1;
                push(cle_pkg::ACT_END, 8'd0);
            end else if (b == cle_pkg::BYTE_BS || b == cle_pkg::BYTE_DEL) begin
                if (col > 0) erase_char();
                else push(cle_pkg::ACT_BELL, 8'd0);
            end else if (b == cle_pkg::BYTE_KILL) begin
                while (col > 0) erase_char();
            end else if (b == cle_pkg::BYTE_WERASE) begin
                while (col > 0 && is_space_like(line_buf[col-1])) erase_char();
                while (col > 0 && !is_space_like(line_buf[col-1])) erase_char();
            end else if (!(((b >= cle_pkg::BYTE_SPACE) && (b <= cle_pkg::BYTE_TILDE)) ||
                           ((b >= cle_pkg::BYTE_TAB) && (b <= cle_pkg::BYTE_CR)))) begin
                push(cle_pkg::ACT_BELL, 8'd0);
            end else begin
                if (col >= LINE_LEN) begin
                    push(cle_pkg::ACT_NEWLINE, 8'd0);
                    col = 0;
                end
                line_buf[col] = b;
                col++;
                push(cle_pkg::ACT_ECHO, b);
            end

            if (owed_q.size() > first) owed_q[owed_q.size()-1].last = 1'b1;
        endfunction

        // Compare one accepted echo word with the oldest owed word.
        function void check_word(logic [15:0] data, logic last);
            t_echo_word want;
            if (owed_q.size() == 0) begin
                errors++;
                $display(
                    "%0t: unexpected word: expected none, got act %0d chr %0d last %0d",
                    $time, data[2:0], data[10:3], last);
                return;
            end
            want = owed_q.pop_front();
            if (data[2:0] !== want.action || data[10:3] !== want.ch ||
                data[15:11] !== 5'd0 || last !== want.last) begin
                errors++;
                $display(
                    "%0t: mismatch: expected act %0d chr %0d pad 0 last %0d,",
                    $time, want.action, want.ch, want.last);
                $display(
                    "%0t:           got act %0d chr %0d pad %0d last %0d",
                    $time, data[2:0], data[10:3], data[15:11], last);
            end
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;    // [7:0] in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [2:0] action, [10:3] out_char, [15:11] zero
    logic        m_axis_tlast;

    t_echo_scoreboard sb;
    bit               calm = 1'b0;        // no idling on either side once set
    bit               hold_req = 1'b0;    // ask the receiver for one long hold-off

    console_line_editor_top #(
        .LINE_LENGTH (LINE_LEN)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Overall time limit: far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Sample every echo word taken at a rising edge; values read here are the
    // ones that held just before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_word(m_axis_tdata, m_axis_tlast);
    end

    // Receiver: random stall bursts, one long hold-off on request, none when calm.
    initial begin
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Offer one byte, hold it until taken, note it, then maybe idle a burst.
    // Valid stays high straight into the next byte when no idle follows.
    task automatic send_byte(input logic [7:0] b);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_byte(b);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // Mostly typing with words and spaces, some editing, some noise. Session
    // end is kept out of this mix: it can only be undone by a reset.
    function automatic logic [7:0] pick_keystroke();
        int unsigned roll;
        logic [7:0]  b;
        roll = $urandom_range(0, 99);
        if (roll < 58)      b = 8'($urandom_range(33, 126));
        else if (roll < 66) b = cle_pkg::BYTE_SPACE;
        else if (roll < 70) b = 8'($urandom_range(cle_pkg::BYTE_TAB, cle_pkg::BYTE_CR));
        else if (roll < 76)
            b = ($urandom_range(0, 1) != 0) ? cle_pkg::BYTE_BS : cle_pkg::BYTE_DEL;
        else if (roll < 78) b = cle_pkg::BYTE_KILL;
        else if (roll < 85) b = cle_pkg::BYTE_WERASE;
        else if (roll < 92) b = 8'($urandom_range(128, 255));
        else begin
            // other control bytes; an EOT here only rings the bell away from column 0
            do b = 8'($urandom_range(0, 31));
            while ((b >= cle_pkg::BYTE_BS && b <= cle_pkg::BYTE_CR) ||
                   b == cle_pkg::BYTE_KILL || b == cle_pkg::BYTE_WERASE);
            if (b == cle_pkg::BYTE_EOT && sb.col == 0) b = 8'd27;
        end
        return b;
    endfunction

    initial begin
        logic [7:0] opening [] = '{
            cle_pkg::BYTE_BS, cle_pkg::BYTE_DEL,       // erase at column 0: bell
            cle_pkg::BYTE_KILL, cle_pkg::BYTE_WERASE,  // nothing to erase: no word
            8'd0, 8'd255, 8'd128,                      // unknown bytes: bell
            8'd65, cle_pkg::BYTE_EOT,                  // EOT away from column 0: bell
            cle_pkg::BYTE_SPACE, cle_pkg::BYTE_TILDE, cle_pkg::BYTE_TAB,
            cle_pkg::BYTE_CR, 8'd31,
            cle_pkg::BYTE_DEL, 8'd120,
            cle_pkg::BYTE_WERASE, cle_pkg::BYTE_WERASE, cle_pkg::BYTE_BS,
            8'd12, 8'd10, 8'd98, cle_pkg::BYTE_WERASE, cle_pkg::BYTE_KILL
        };
        sb = new();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening[i]) send_byte(opening[i]);

        // Long receiver hold-off while the sender keeps offering bytes.
        hold_req = 1'b1;
        for (int k = 0; k < RANDOM_KEYS; k++) begin
            if (k == RANDOM_KEYS - CALM_KEYS) calm = 1'b1;
            send_byte(pick_keystroke());
        end

        // Clear the line, end the session, then bytes that must be dropped.
        send_byte(cle_pkg::BYTE_KILL);
        send_byte(cle_pkg::BYTE_EOT);
        send_byte(8'd122);
        send_byte(cle_pkg::BYTE_EOT);
        send_byte(8'd255);
        s_axis_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);

        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
